FILE: hdl/wbd_pkg.sv
// Shared types and constants for the window back-reference decoder.
package wbd_pkg;

    // Default depth of the decoded-byte history
    localparam int HISTORY_DEPTH_DEF = 32;

    // Distance base: distance is this value minus the code's upper five bits
    localparam int DIST_BASE = 32;

    // Code that marks the following byte as a literal
    localparam logic [7:0] ESCAPE_CODE = 8'hFF;

    // Mask of the length field in a back-reference code
    localparam logic [2:0] LEN_MASK = 3'd7;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ESCAPED,
        ST_COPY
    } wbd_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_lit;    // emit the input byte as a literal
        logic load_first;  // emit first byte of a back-reference taken from the input
        logic load_next;   // emit next byte of the held back-reference
        logic clear;       // drop history state at end of chunk
    } wbd_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic slot_free;   // output register may be loaded this cycle
        logic is_escape;   // input byte is the escape code
        logic len_one;     // input back-reference has length one
        logic remain_one;  // one byte of the held back-reference is left
        logic held_last;   // held back-reference closes its chunk
    } wbd_status_t;

endpackage

FILE: hdl/window_backreference_decoder.sv
// Top level of the window back-reference decoder.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_byte, last_in_chunk
// out      output     out_valid / out_ready out_byte, last_of_run, bad_reference
//
// An escape gives no beat; a literal gives one beat. In a back-reference,
// the first byte is emitted in the accept cycle, the rest from the copy
// state, one per cycle, paced by the single output register. Reset clears
// pointer, fill count and state; history contents are gated by the fill
// count and need no clearing.
// A stall on out holds the output register and closes in_ready.
module window_backreference_decoder
#(
    parameter int HISTORY_DEPTH = wbd_pkg::HISTORY_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       last_in_chunk,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       bad_reference
);

    wbd_pkg::wbd_cmd_t    cmd;
    wbd_pkg::wbd_status_t status;

    // Sequence escapes, literals and copies
    wbd_controller u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .last_in_chunk (last_in_chunk),
        .status        (status),
        .cmd           (cmd)
    );

    // Keep history and drive the output beat
    wbd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_byte       (in_byte),
        .last_in_chunk (last_in_chunk),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .bad_reference (bad_reference)
    );

endmodule

FILE: hdl/wbd_controller.sv
// Controller state machine for the window back-reference decoder.
module wbd_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                last_in_chunk,
    input  wbd_pkg::wbd_status_t status,
    output wbd_pkg::wbd_cmd_t   cmd
);

    wbd_pkg::wbd_state_t state_reg;
    wbd_pkg::wbd_state_t state_next;
    logic                in_fire;

    // Hold the state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wbd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Input beat taken in the states that open in_ready on a free slot
    assign in_fire = in_valid && status.slot_free;

    // Decide next state and issue datapath commands
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.load_lit   = 1'b0;
        cmd.load_first = 1'b0;
        cmd.load_next  = 1'b0;
        cmd.clear      = 1'b0;
        case (state_reg)
            wbd_pkg::ST_IDLE:
            begin
                in_ready = status.slot_free;
                if (in_fire)
                begin
                    if (status.is_escape)
                    begin
                        // Drop a pending escape when the chunk ends on it
                        if (last_in_chunk)
                        begin
                            cmd.clear = 1'b1;
                        end
                        else
                        begin
                            state_next = wbd_pkg::ST_ESCAPED;
                        end
                    end
                    else
                    begin
                        cmd.load_first = 1'b1;
                        if (status.len_one)
                        begin
                            cmd.clear = last_in_chunk;
                        end
                        else
                        begin
                            state_next = wbd_pkg::ST_COPY;
                        end
                    end
                end
            end
            wbd_pkg::ST_ESCAPED:
            begin
                in_ready = status.slot_free;
                if (in_fire)
                begin
                    cmd.load_lit = 1'b1;
                    cmd.clear    = last_in_chunk;
                    state_next   = wbd_pkg::ST_IDLE;
                end
            end
            wbd_pkg::ST_COPY:
            begin
                // Advance one copied byte whenever the output register frees up
                if (status.slot_free)
                begin
                    cmd.load_next = 1'b1;
                    if (status.remain_one)
                    begin
                        cmd.clear  = status.held_last;
                        state_next = wbd_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = wbd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/wbd_datapath.sv
// History window, copy context and output register of the back-reference decoder.
module wbd_datapath
#(
    parameter int HISTORY_DEPTH = wbd_pkg::HISTORY_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           in_byte,
    input  logic                 last_in_chunk,
    input  wbd_pkg::wbd_cmd_t    cmd,
    output wbd_pkg::wbd_status_t status,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [7:0]           out_byte,
    output logic                 last_of_run,
    output logic                 bad_reference
);

    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = PTR_W + 1;

    logic [7:0]        history_reg [HISTORY_DEPTH];
    logic [PTR_W-1:0]  wp_reg;
    logic [PTR_W-1:0]  wp_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [4:0]        code_hi_reg;
    logic [2:0]        remain_reg;
    logic [2:0]        remain_next;
    logic              held_last_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              out_bad_reg;

    logic              emit;
    logic [4:0]        hi_sel;
    logic [FILL_W-1:0] copy_dist;
    logic [PTR_W-1:0]  rd_idx;
    logic              bad_copy;
    logic [7:0]        copy_byte;
    logic [7:0]        emit_byte;
    logic              emit_bad;
    logic              emit_last;

    assign emit = cmd.load_lit || cmd.load_first || cmd.load_next;

    // Locate the copy source behind the write position
    assign hi_sel    = cmd.load_next ? code_hi_reg : in_byte[7:3];
    assign copy_dist = FILL_W'(wbd_pkg::DIST_BASE) - FILL_W'(hi_sel);
    assign rd_idx    = PTR_W'(FILL_W'(wp_reg) + FILL_W'(HISTORY_DEPTH) - copy_dist);
    assign bad_copy  = (fill_reg < copy_dist);
    assign copy_byte = bad_copy ? 8'd0 : history_reg[rd_idx];

    // Select the byte and flags for the output beat
    always_comb
    begin
        emit_byte = copy_byte;
        emit_bad  = bad_copy;
        emit_last = (remain_reg == 3'd1);
        if (cmd.load_lit)
        begin
            emit_byte = in_byte;
            emit_bad  = 1'b0;
            emit_last = 1'b1;
        end
        else if (cmd.load_first)
        begin
            emit_last = ((in_byte[2:0] & wbd_pkg::LEN_MASK) == 3'd0);
        end
    end

    // Advance pointer, fill count and remaining length
    always_comb
    begin
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        remain_next = remain_reg;
        if (emit)
        begin
            wp_next = wp_reg + PTR_W'(1);
            if (fill_reg < FILL_W'(HISTORY_DEPTH))
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
        if (cmd.clear)
        begin
            wp_next   = '0;
            fill_next = '0;
        end
        if (cmd.load_first)
        begin
            remain_next = in_byte[2:0] & wbd_pkg::LEN_MASK;
        end
        else if (cmd.load_next)
        begin
            remain_next = remain_reg - 3'd1;
        end
    end

    // Load on emit, drop once the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload: history, copy context and output beat
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            history_reg[wp_reg] <= emit_byte;
            out_byte_reg        <= emit_byte;
            out_last_reg        <= emit_last;
            out_bad_reg         <= emit_bad;
        end
        if (cmd.load_first)
        begin
            code_hi_reg   <= in_byte[7:3];
            held_last_reg <= last_in_chunk;
        end
    end

    assign status.slot_free  = !out_valid_reg || out_ready;
    assign status.is_escape  = (in_byte == wbd_pkg::ESCAPE_CODE);
    assign status.len_one    = ((in_byte[2:0] & wbd_pkg::LEN_MASK) == 3'd0);
    assign status.remain_one = (remain_reg == 3'd1);
    assign status.held_last  = held_last_reg;

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign last_of_run   = out_last_reg;
    assign bad_reference = out_bad_reg;

endmodule

FILE: hdl/wbd_checker.sv
// Port-level checks for the window back-reference decoder, bound to the top level.
module wbd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] in_byte,
    input logic       last_in_chunk,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       bad_reference
);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(last_of_run) && $stable(bad_reference))
        else $error("stalled output beat changed");

    // A bad reference always reads as zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_reference |-> out_byte == 8'd0)
        else $error("bad reference with non-zero byte");

    // Input is taken only when the output register can move
    a_ready_slot: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || out_ready)
        else $error("input ready while output is blocked");

    // Mid-run, no input is taken
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !in_ready)
        else $error("input ready in the middle of a copy run");

    // The next byte of a run follows a taken beat at once
    a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("gap in copy run");

endmodule

bind window_backreference_decoder wbd_checker u_wbd_checker (.*);

FILE: tb/tb_window_backreference_decoder.sv
// Testbench for the window back-reference decoder: directed and random beats checked by a scoreboard.
`timescale 1ns / 100ps

module tb_window_backreference_decoder;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_SLACK  = 20;
    localparam int LONG_HOLD    = 300;
    localparam int WINDOW       = wbd_pkg::HISTORY_DEPTH_DEF;

    // One decoded output beat as the block should present it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       bad_reference;
    } decoded_beat_t;

    // Window model and queue of decoded bytes still to arrive
    class wbd_scoreboard;
        logic [7:0]    window_bytes [WINDOW];
        logic [4:0]    wr_ptr;
        int unsigned   fill_level;
        bit            escape_pending;
        decoded_beat_t expected_bytes [$];
        int unsigned   error_count;

        function void clear_window();
            foreach (window_bytes[i])
                window_bytes[i] = 8'h00;
            wr_ptr         = '0;
            fill_level     = 0;
            escape_pending = 1'b0;
        endfunction

        function void append_byte(logic [7:0] b);
            window_bytes[wr_ptr] = b;
            wr_ptr = wr_ptr + 5'd1;
            if (fill_level < WINDOW)
                fill_level++;
        endfunction

        // Queue one expected beat behind those already waiting
        function void note_beat(decoded_beat_t beat);
            expected_bytes.insert(expected_bytes.size(), beat);
        endfunction

        // Work out the bytes that one accepted input beat produces
        function void predict_decode(logic [7:0] code, logic last);
            int unsigned copy_len;
            int unsigned distance;
            logic [4:0]  rd_idx;
            logic [7:0]  b;
            logic        bad;
            if (escape_pending)
            begin
                escape_pending = 1'b0;
                append_byte(code);
                note_beat(decoded_beat_t'{code, 1'b1, 1'b0});
            end
            else if (code == wbd_pkg::ESCAPE_CODE)
            begin
                escape_pending = 1'b1;
            end
            else
            begin
                copy_len = (code[2:0] & wbd_pkg::LEN_MASK) + 1;
                distance = wbd_pkg::DIST_BASE - code[7:3];
                for (int unsigned k = 0; k < copy_len; k++)
                begin
                    // Reads before the chunk start give zero and flag it
                    if (fill_level < distance)
                    begin
                        b   = 8'h00;
                        bad = 1'b1;
                    end
                    else
                    begin
                        rd_idx = wr_ptr - 5'(distance);
                        b      = window_bytes[rd_idx];
                        bad    = 1'b0;
                    end
                    append_byte(b);
                    note_beat(decoded_beat_t'{b, (k + 1 == copy_len), bad});
                end
            end
            if (last)
                clear_window();
        endfunction

        // Compare an output beat with the oldest expected byte
        function void check_decoded(logic [7:0] b, logic lr, logic bad);
            decoded_beat_t exp_beat;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected beat out_byte=%02h last_of_run=%0b bad_reference=%0b",
                         $time, b, lr, bad);
                error_count++;
                return;
            end
            exp_beat = expected_bytes.pop_front();
            if (b !== exp_beat.out_byte)
            begin
                $display("%0t: out_byte expected %02h actual %02h", $time, exp_beat.out_byte, b);
                error_count++;
            end
            if (lr !== exp_beat.last_of_run)
            begin
                $display("%0t: last_of_run expected %0b actual %0b",
                         $time, exp_beat.last_of_run, lr);
                error_count++;
            end
            if (bad !== exp_beat.bad_reference)
            begin
                $display("%0t: bad_reference expected %0b actual %0b",
                         $time, exp_beat.bad_reference, bad);
                error_count++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       last_in_chunk;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       bad_reference;

    wbd_scoreboard sb;
    int unsigned   tx_idle_pct;
    int unsigned   rx_stall_pct;
    bit            long_hold_req;
    int unsigned   cycle_count;

    window_backreference_decoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .last_in_chunk (last_in_chunk),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .bad_reference (bad_reference)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Abandon the run if it never drains
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Output side: check each beat, then pick out_ready for the next cycle
    initial
    begin
        int hold_count;
        hold_count = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_decoded(out_byte, last_of_run, bad_reference);
            if (long_hold_req)
            begin
                hold_count    = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_count > 0)
            begin
                hold_count--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Offer one beat and hold it until taken, then maybe go idle
    task automatic offer_byte(input logic [7:0] b, input logic last);
        in_valid      <= 1'b1;
        in_byte       <= b;
        last_in_chunk <= last;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sb.predict_decode(b, last);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Pause the input until every decoded byte has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // Random chunks: mostly well-formed references and escaped literals
    task automatic send_random(input int unsigned n_items);
        int unsigned chunk_left;
        int unsigned pick;
        int unsigned copy_len;
        int unsigned distance;
        int unsigned reach;
        logic [7:0]  code;
        logic        last;
        chunk_left = 0;
        for (int unsigned i = 0; i < n_items; i++)
        begin
            if (chunk_left == 0)
                chunk_left = ($urandom_range(99) < 15) ? $urandom_range(1, 4)
                                                       : $urandom_range(10, 45);
            last = (chunk_left == 1);
            chunk_left--;
            pick = $urandom_range(99);
            if (sb.escape_pending || pick < 10)
            begin
                code = 8'($urandom);
            end
            else if (pick < 30)
            begin
                code = wbd_pkg::ESCAPE_CODE;
            end
            else
            begin
                // Keep most distances inside the filled part of the window
                copy_len = $urandom_range(1, 8);
                reach    = (sb.fill_level == 0) ? 1 : sb.fill_level;
                distance = (pick < 85) ? $urandom_range(1, reach) : $urandom_range(1, WINDOW);
                code     = {5'(wbd_pkg::DIST_BASE - distance), 3'(copy_len - 1)};
            end
            offer_byte(code, last);
        end
    endtask

    // Main sequence
    initial
    begin
        sb = new;
        sb.clear_window();
        sb.error_count = 0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        long_hold_req  = 1'b0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        in_byte       <= 8'h00;
        last_in_chunk <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: references into an empty window
        offer_byte(8'h00, 1'b0);
        offer_byte(8'h07, 1'b0);
        // Escaped literals at the extremes, escaped escape included
        offer_byte(wbd_pkg::ESCAPE_CODE, 1'b0);
        offer_byte(8'h00, 1'b0);
        offer_byte(wbd_pkg::ESCAPE_CODE, 1'b0);
        offer_byte(wbd_pkg::ESCAPE_CODE, 1'b0);
        offer_byte(wbd_pkg::ESCAPE_CODE, 1'b0);
        offer_byte(8'hAA, 1'b0);
        offer_byte(wbd_pkg::ESCAPE_CODE, 1'b0);
        offer_byte(8'h55, 1'b0);
        // Overlapping copies at distance one and two
        offer_byte(8'hFE, 1'b0);
        offer_byte(8'hF7, 1'b0);
        offer_byte(8'hF7, 1'b0);
        offer_byte(8'hF7, 1'b0);
        offer_byte(8'hF7, 1'b0);
        // Full window: longest reach, longest copy
        offer_byte(8'h07, 1'b0);
        // Reference closing the chunk, then a read into the cleared window
        offer_byte(8'hF0, 1'b1);
        offer_byte(8'hF8, 1'b0);
        // Escape closing the chunk is dropped, next byte is a reference
        offer_byte(wbd_pkg::ESCAPE_CODE, 1'b1);
        offer_byte(8'h01, 1'b0);
        offer_byte(wbd_pkg::ESCAPE_CODE, 1'b0);
        offer_byte(8'h3C, 1'b1);
        wait_drained();

        // No idling, with one long output hold so the block backs up
        long_hold_req = 1'b1;
        send_random(45);
        wait_drained();

        // Sender idle half the time
        tx_idle_pct = 50;
        send_random(45);
        wait_drained();

        // Receiver stalling half the time
        tx_idle_pct  = 0;
        rx_stall_pct = 50;
        send_random(45);
        wait_drained();

        // Light idling on both sides
        tx_idle_pct  = 7;
        rx_stall_pct = 7;
        send_random(45);
        wait_drained();

        if (sb.expected_bytes.size() != 0)
        begin
            $display("%0t: %0d expected bytes never arrived", $time, sb.expected_bytes.size());
            sb.error_count++;
        end
        if (sb.error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: window_backreference_decoder.f
hdl/wbd_pkg.sv
hdl/wbd_controller.sv
hdl/wbd_datapath.sv
hdl/window_backreference_decoder.sv
hdl/wbd_checker.sv
tb/tb_window_backreference_decoder.sv
